// ===== hw/rtl/scg_pkg.sv =====
// Package: widths, command type, register indexes and the sine ROM builder.
`timescale 1ns / 1ps
`default_nettype none
package scg_pkg;

  localparam int RANGE_W    = 16;
  localparam int BEAM_W     = 12;
  localparam int ANGLE_W    = 16;
  localparam int COUNT_W    = 13;
  localparam int COORD_W    = 17;
  localparam int SUM_W      = 30;
  localparam int MAX_BEAMS  = 4096;
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int CFG_W      = 16;
  localparam int CFG_AW     = 2;
  localparam int PROD_W     = RANGE_W + 1 + 16;

  localparam logic [CFG_AW-1:0] CFG_GAP_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MIN_POINTS    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ANGLE_START   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_ANGLE_STEP    = 2'd3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  // One classified beam handed from front to back.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               accum;
    logic               gap;
    logic               last;
    logic [ANGLE_W-1:0] theta;
  } cmd_t;

  typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

  // Shift-and-subtract quotient, only used while building the ROM.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave Taylor series in Q30, rounded to Q1.15.
  function automatic logic signed [15:0] sine_q15(input logic [15:0] b);
    longint unsigned f;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint          sum;
    longint          val;
    logic [1:0]      quad;
    quad = b[15:14];
    f    = {50'd0, b[13:0]};
    if (quad[0]) f = 64'd16384 - f;
    x    = (f * HALF_PI_Q30) >> 14;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      d    = longint'(4 * n * n + 2 * n);
      term = div_u64((term * x2) >> 30, d);
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    val = (sum * 32767 + ONE_Q30 / 2) / ONE_Q30;
    if (val > 32767) val = 32767;
    if (quad[1]) val = -val;
    return 16'(val);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      t[k] = sine_q15(16'(k << (16 - SINE_AW)));
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scg_if.sv =====
// Stream interfaces for beam requests and cluster results.
`timescale 1ns / 1ps
`default_nettype none
interface scg_beam_if;
  logic                          valid;
  logic                          ready;
  logic [scg_pkg::RANGE_W-1:0]   range_mm;
  logic                          range_valid;
  logic [scg_pkg::BEAM_W-1:0]    beam_index;
  logic                          last_beam;
  modport source (output valid, range_mm, range_valid, beam_index, last_beam, input ready);
  modport sink   (input valid, range_mm, range_valid, beam_index, last_beam, output ready);
endinterface

interface scg_cluster_if;
  logic                               valid;
  logic                               ready;
  logic signed [scg_pkg::COORD_W-1:0] centroid_x_mm;
  logic signed [scg_pkg::COORD_W-1:0] centroid_y_mm;
  logic [scg_pkg::COUNT_W-1:0]        point_count;
  logic                               scan_done;
  modport source (output valid, centroid_x_mm, centroid_y_mm, point_count, scan_done,
                  input ready);
  modport sink   (input valid, centroid_x_mm, centroid_y_mm, point_count, scan_done,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/scan_gap_cluster_centroids.sv =====
// Top level: lidar scan segmentation into range-jump clusters with centroids.
//
// in_beam carries one beam request per handshake (range, validity, index,
// end-of-scan flag); out_cluster carries centroid results (x, y, count,
// scan_done). cfg_we/cfg_addr/cfg_wdata write the four setup registers
// (gap threshold, minimum cluster size, start angle, angle step); the user
// must do so only while idle, as the block itself does not enforce it.
// The front end checks the range jump and forms the beam angle as the
// request is taken, then queues it (two entries) for the back end.
// The back end reads sine and cosine of a valid beam from one ROM port,
// then runs one multiply stage and one accumulate; an invalid beam skips
// them. A beam that closes a reportable cluster, or ends a scan with one
// open, adds a serial divide plus a load of the result register.
// The end of a scan always gives one scan_done result, a bare marker with
// point_count 0 when the open cluster is empty or too small.
// Reset (synchronous, active low) empties the queue, clears the cluster and
// loads the register defaults. A stalled receiver holds the result register;
// the back end waits, the queue fills and in_beam.ready falls.
`timescale 1ns / 1ps
`default_nettype none
module scan_gap_cluster_centroids (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  scg_beam_if.sink                           in_beam,
  scg_cluster_if.source                      out_cluster,
  input  wire logic                          cfg_we,
  input  wire logic [scg_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [scg_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [scg_pkg::RANGE_W-1:0] gap_threshold_r;
  logic [scg_pkg::COUNT_W-1:0] min_points_r;
  logic [scg_pkg::ANGLE_W-1:0] angle_start_r;
  logic [scg_pkg::ANGLE_W-1:0] angle_step_r;

  logic          q_push, q_pop, q_full, q_empty;
  scg_pkg::cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_threshold_r <= 16'd300;
      min_points_r    <= '0;
      angle_start_r   <= '0;
      angle_step_r    <= 16'd91;
    end else if (cfg_we) begin
      case (cfg_addr)
        scg_pkg::CFG_GAP_THRESHOLD: gap_threshold_r <= cfg_wdata;
        scg_pkg::CFG_MIN_POINTS:    min_points_r    <= cfg_wdata[scg_pkg::COUNT_W-1:0];
        scg_pkg::CFG_ANGLE_START:   angle_start_r   <= cfg_wdata;
        scg_pkg::CFG_ANGLE_STEP:    angle_step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  scg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_beam       (in_beam),
    .gap_threshold (gap_threshold_r),
    .angle_start   (angle_start_r),
    .angle_step    (angle_step_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  scg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  scg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .min_points  (min_points_r),
    .q_empty     (q_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_cluster (out_cluster)
  );

  // A zero count only ever appears on an end-of-scan marker.
  a_marker_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_cluster.valid && (out_cluster.point_count == '0) |-> out_cluster.scan_done)
    else $error("zero-count result without scan_done");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_cluster.valid |-> (out_cluster.point_count <= 13'(scg_pkg::MAX_BEAMS)))
    else $error("cluster count above cap");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |-> !q_full)
    else $error("queue push while full");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_cluster.valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== hw/rtl/scg_front.sv =====
// Front end: accepts beams, detects range jumps, computes beam angle.
`timescale 1ns / 1ps
`default_nettype none
module scg_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  scg_beam_if.sink                           in_beam,
  input  wire logic [scg_pkg::RANGE_W-1:0]   gap_threshold,
  input  wire logic [scg_pkg::ANGLE_W-1:0]   angle_start,
  input  wire logic [scg_pkg::ANGLE_W-1:0]   angle_step,
  input  wire logic                          q_full,
  output logic                               q_push,
  output scg_pkg::cmd_t                      q_data
);

  logic [scg_pkg::RANGE_W-1:0] last_range_r;
  logic                        prev_valid_r;
  logic [scg_pkg::RANGE_W-1:0] diff;
  logic [scg_pkg::ANGLE_W-1:0] step_prod;

  assign in_beam.ready = !q_full;
  assign q_push        = in_beam.valid && !q_full;

  always_comb begin
    if (in_beam.range_mm > last_range_r) diff = in_beam.range_mm - last_range_r;
    else                                 diff = last_range_r - in_beam.range_mm;
    step_prod        = scg_pkg::ANGLE_W'(in_beam.beam_index * angle_step);
    q_data.range_mm  = in_beam.range_mm;
    q_data.accum     = in_beam.range_valid;
    q_data.gap       = in_beam.range_valid && prev_valid_r && (diff > gap_threshold);
    q_data.last      = in_beam.last_beam;
    q_data.theta     = angle_start + step_prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_range_r <= '0;
      prev_valid_r <= 1'b0;
    end else if (q_push) begin
      if (in_beam.last_beam) begin
        last_range_r <= '0;
        prev_valid_r <= 1'b0;
      end else if (in_beam.range_valid) begin
        last_range_r <= in_beam.range_mm;
        prev_valid_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scg_fifo.sv =====
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module scg_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  scg_pkg::cmd_t      push_data,
  input  wire logic          pop,
  output scg_pkg::cmd_t      pop_data,
  output logic               full,
  output logic               empty
);

  scg_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scg_div.sv =====
// Serial signed divider: x and y sums by the point count, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module scg_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [scg_pkg::SUM_W-1:0]    dvd_x,
  input  wire logic signed [scg_pkg::SUM_W-1:0]    dvd_y,
  input  wire logic [scg_pkg::COUNT_W-1:0]         den,
  output logic                                     done,
  output logic signed [scg_pkg::SUM_W-1:0]         quot_x,
  output logic signed [scg_pkg::SUM_W-1:0]         quot_y
);

  localparam int CntW = $clog2(scg_pkg::SUM_W);

  logic                          busy_r;
  logic [CntW-1:0]               cnt_r;
  logic [scg_pkg::SUM_W-1:0]     qx_r, qy_r;
  logic [scg_pkg::COUNT_W-1:0]   rx_r, ry_r;
  logic [scg_pkg::COUNT_W-1:0]   den_r;
  logic                          neg_x_r, neg_y_r;
  logic                          done_r;
  logic [scg_pkg::COUNT_W:0]     sh_x, sh_y;
  logic                          ge_x, ge_y;

  always_comb begin
    sh_x = {rx_r, qx_r[scg_pkg::SUM_W-1]};
    sh_y = {ry_r, qy_r[scg_pkg::SUM_W-1]};
    ge_x = sh_x >= {1'b0, den_r};
    ge_y = sh_y >= {1'b0, den_r};
  end

  assign done   = done_r;
  assign quot_x = neg_x_r ? -$signed(qx_r) : $signed(qx_r);
  assign quot_y = neg_y_r ? -$signed(qy_r) : $signed(qy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        den_r   <= den;
        rx_r    <= '0;
        ry_r    <= '0;
        neg_x_r <= dvd_x[scg_pkg::SUM_W-1];
        neg_y_r <= dvd_y[scg_pkg::SUM_W-1];
        qx_r    <= dvd_x[scg_pkg::SUM_W-1] ? 30'(-dvd_x) : dvd_x;
        qy_r    <= dvd_y[scg_pkg::SUM_W-1] ? 30'(-dvd_y) : dvd_y;
      end else if (busy_r) begin
        rx_r <= ge_x ? 13'(sh_x - {1'b0, den_r}) : sh_x[scg_pkg::COUNT_W-1:0];
        ry_r <= ge_y ? 13'(sh_y - {1'b0, den_r}) : sh_y[scg_pkg::COUNT_W-1:0];
        qx_r <= {qx_r[scg_pkg::SUM_W-2:0], ge_x};
        qy_r <= {qy_r[scg_pkg::SUM_W-2:0], ge_y};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(scg_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scg_back.sv =====
// Back end: point geometry, cluster sums, centroid requests and result register.
`timescale 1ns / 1ps
`default_nettype none
module scg_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [scg_pkg::COUNT_W-1:0]   min_points,
  input  wire logic                          q_empty,
  input  scg_pkg::cmd_t                      q_data,
  output logic                               q_pop,
  scg_cluster_if.source                      out_cluster
);

  typedef enum logic [3:0] {
    B_IDLE, B_CHECK, B_POINT, B_SIN, B_COS, B_ACC, B_LAST, B_DIV, B_EMIT
  } state_t;

  localparam scg_pkg::sine_rom_t SineRom = scg_pkg::build_sine_rom();

  state_t                              state_r;
  scg_pkg::cmd_t                       cmd_r;
  logic signed [scg_pkg::SUM_W-1:0]    sum_x_r, sum_y_r;
  logic [scg_pkg::COUNT_W-1:0]         count_r;
  logic [scg_pkg::SINE_AW-1:0]         rom_addr;
  logic signed [15:0]                  rom_q_r;
  logic signed [15:0]                  sin_r;
  logic signed [scg_pkg::PROD_W-1:0]   prod_x_r, prod_y_r;
  logic signed [scg_pkg::PROD_W-1:0]   tx, ty;
  logic [scg_pkg::ANGLE_W-1:0]         theta_c;
  logic                                reportable;
  logic                                div_start_r;
  logic                                div_done;
  logic signed [scg_pkg::SUM_W-1:0]    quot_x, quot_y;
  logic [scg_pkg::COUNT_W-1:0]         res_cnt_r;
  logic                                res_done_r;
  logic                                res_marker_r;
  logic                                out_free;
  logic                                out_valid_r;

  scg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start_r),
    .dvd_x  (sum_x_r),
    .dvd_y  (sum_y_r),
    .den    (count_r),
    .done   (div_done),
    .quot_x (quot_x),
    .quot_y (quot_y)
  );

  assign reportable = (count_r != '0) && (count_r >= min_points);
  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign out_free   = !out_valid_r || out_cluster.ready;
  assign out_cluster.valid = out_valid_r;
  assign theta_c    = cmd_r.theta + 16'h4000;

  always_comb begin
    if (state_r == B_SIN) rom_addr = theta_c[scg_pkg::ANGLE_W-1 -: scg_pkg::SINE_AW];
    else                  rom_addr = cmd_r.theta[scg_pkg::ANGLE_W-1 -: scg_pkg::SINE_AW];
    // truncate toward zero on the divide by 32768
    tx = prod_x_r + (prod_x_r[scg_pkg::PROD_W-1] ? 33'sd32767 : 33'sd0);
    ty = prod_y_r + (prod_y_r[scg_pkg::PROD_W-1] ? 33'sd32767 : 33'sd0);
  end

  always_ff @(posedge clk) begin
    rom_q_r <= SineRom[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      count_r      <= '0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      res_done_r   <= 1'b0;
      res_marker_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_cluster.ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_data;
            state_r <= B_CHECK;
          end
        end
        B_CHECK: begin
          state_r <= B_POINT;
          if (cmd_r.gap) begin
            if (reportable) begin
              div_start_r  <= 1'b1;
              res_cnt_r    <= count_r;
              res_done_r   <= 1'b0;
              res_marker_r <= 1'b0;
              state_r      <= B_DIV;
            end else begin
              sum_x_r <= '0;
              sum_y_r <= '0;
              count_r <= '0;
            end
          end
        end
        B_POINT: begin
          if (cmd_r.accum && (count_r < 13'(scg_pkg::MAX_BEAMS))) state_r <= B_SIN;
          else                                                    state_r <= B_LAST;
        end
        B_SIN: begin
          sin_r   <= rom_q_r;
          state_r <= B_COS;
        end
        B_COS: begin
          prod_x_r <= $signed({1'b0, cmd_r.range_mm}) * rom_q_r;
          prod_y_r <= $signed({1'b0, cmd_r.range_mm}) * sin_r;
          state_r  <= B_ACC;
        end
        B_ACC: begin
          sum_x_r <= sum_x_r + {{12{tx[32]}}, tx[32:15]};
          sum_y_r <= sum_y_r + {{12{ty[32]}}, ty[32:15]};
          count_r <= count_r + 1'b1;
          state_r <= B_LAST;
        end
        B_LAST: begin
          if (cmd_r.last) begin
            res_done_r <= 1'b1;
            res_cnt_r  <= count_r;
            if (reportable) begin
              div_start_r  <= 1'b1;
              res_marker_r <= 1'b0;
              state_r      <= B_DIV;
            end else begin
              res_marker_r <= 1'b1;
              sum_x_r      <= '0;
              sum_y_r      <= '0;
              count_r      <= '0;
              state_r      <= B_EMIT;
            end
          end else begin
            state_r <= B_IDLE;
          end
        end
        B_DIV: begin
          // sums are latched by the divider at start, so clear once it runs
          if (div_start_r) begin
            sum_x_r <= '0;
            sum_y_r <= '0;
            count_r <= '0;
          end
          if (div_done) state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_cluster.centroid_x_mm  <= res_marker_r ? '0 : quot_x[scg_pkg::COORD_W-1:0];
            out_cluster.centroid_y_mm  <= res_marker_r ? '0 : quot_y[scg_pkg::COORD_W-1:0];
            out_cluster.point_count    <= res_marker_r ? '0 : res_cnt_r;
            out_cluster.scan_done      <= res_done_r;
            state_r                    <= res_done_r ? B_IDLE : B_POINT;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for scan_gap_cluster_centroids: random and directed scans against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import scg_pkg::*;

  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint          Q30_ONE = 64'sd1073741824;
  localparam int              LIMIT   = 1_000_000;

  typedef struct {
    logic [RANGE_W-1:0] range_mm;
    logic               range_valid;
    logic [BEAM_W-1:0]  beam_index;
    logic               last_beam;
  } beam_t;

  typedef struct {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COUNT_W-1:0] count;
    logic               done;
  } cluster_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;

  scg_beam_if    bi();
  scg_cluster_if co();

  scan_gap_cluster_centroids u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_beam     (bi.sink),
    .out_cluster (co.source),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata)
  );

  always #6 clk = ~clk;

  beam_t    beam_q[$];
  cluster_t centroid_q[$];
  int       errors = 0;
  int       send_idle = 12;
  int       recv_idle = 48;
  int       hold_token = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  longint   cycles = 0;

  // predictor state and registers
  logic signed [15:0] sin_rom [SINE_DEPTH];
  logic [15:0]        gap_thr;
  logic [COUNT_W-1:0] min_pts;
  logic [15:0]        ang_start;
  logic [15:0]        ang_step;
  logic [15:0]        last_rng;
  logic               prev_valid;
  longint             acc_x;
  longint             acc_y;
  int                 npts;

  function automatic logic signed [15:0] taylor_sine(input logic [15:0] b);
    longint unsigned f, x, x2, term;
    longint          s, v;
    f = b[13:0];
    if (b[14]) f = 16384 - f;
    x = (f * HALF_PI) >> 14;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      s = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
    end
    if (s < 0) s = 0;
    v = (s * 32767 + Q30_ONE / 2) / Q30_ONE;
    if (v > 32767) v = 32767;
    if (b[15]) v = -v;
    return 16'(v);
  endfunction

  function automatic void clear_cluster();
    acc_x = 0;
    acc_y = 0;
    npts  = 0;
  endfunction

  function automatic void push_centroid(input logic done);
    cluster_t r;
    if (npts > 0 && npts >= min_pts) begin
      r.cx    = 17'(acc_x / npts);
      r.cy    = 17'(acc_y / npts);
      r.count = 13'(npts);
    end else begin
      r.cx = '0;
      r.cy = '0;
      r.count = '0;
    end
    r.done = done;
    centroid_q.insert(centroid_q.size(), r);
  endfunction

  function automatic void predict_beam(input beam_t b);
    logic [15:0] diff, theta;
    longint      s, c;
    if (b.range_valid) begin
      if (prev_valid) begin
        diff = (b.range_mm > last_rng) ? b.range_mm - last_rng
                                       : last_rng - b.range_mm;
        if (diff > gap_thr) begin
          if (npts > 0 && npts >= min_pts) push_centroid(1'b0);
          clear_cluster();
        end
      end
      if (npts < MAX_BEAMS) begin
        theta = 16'(32'(ang_start) + 32'(b.beam_index) * 32'(ang_step));
        s = sin_rom[theta >> 6];
        c = sin_rom[16'(theta + 16'd16384) >> 6];
        acc_x += (longint'(b.range_mm) * c) / 32768;
        acc_y += (longint'(b.range_mm) * s) / 32768;
        npts++;
      end
      last_rng = b.range_mm;
      prev_valid = 1'b1;
    end
    if (b.last_beam) begin
      push_centroid(1'b1);
      clear_cluster();
      last_rng = '0;
      prev_valid = 1'b0;
    end
  endfunction

  // beam driver
  always @(posedge clk) begin
    if (!rst_n) begin
      bi.valid <= 1'b0;
    end else if (!bi.valid || bi.ready) begin
      if (beam_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        bi.valid       <= 1'b1;
        bi.range_mm    <= beam_q[0].range_mm;
        bi.range_valid <= beam_q[0].range_valid;
        bi.beam_index  <= beam_q[0].beam_index;
        bi.last_beam   <= beam_q[0].last_beam;
        void'(beam_q.pop_front());
      end else begin
        bi.valid <= 1'b0;
      end
    end
  end

  // result receiver with optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      co.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 600;
      co.ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      co.ready  <= 1'b0;
    end else begin
      co.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: check results, then predict for the accepted beam
  always @(posedge clk) begin
    cluster_t e;
    if (rst_n) begin
      if (co.valid && co.ready) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d n=%0d done=%0b", $time,
                   co.centroid_x_mm, co.centroid_y_mm, co.point_count, co.scan_done);
          errors++;
        end else begin
          e = centroid_q.pop_front();
          if (co.centroid_x_mm !== e.cx || co.centroid_y_mm !== e.cy ||
              co.point_count !== e.count || co.scan_done !== e.done) begin
            $display("%0t: mismatch expected x=%0d y=%0d n=%0d done=%0b", $time,
                     $signed(e.cx), $signed(e.cy), e.count, e.done);
            $display("%0t:          actual   x=%0d y=%0d n=%0d done=%0b", $time,
                     co.centroid_x_mm, co.centroid_y_mm, co.point_count, co.scan_done);
            errors++;
          end
        end
      end
      if (bi.valid && bi.ready) predict_beam('{bi.range_mm, bi.range_valid,
                                              bi.beam_index, bi.last_beam});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_beam(input int r, input bit v, input int idx, input bit last);
    beam_t b;
    b.range_mm = 16'(r);
    b.range_valid = v;
    b.beam_index = 12'(idx);
    b.last_beam = last;
    beam_q.insert(beam_q.size(), b);
  endtask

  // one scan: runs of nearby ranges with occasional jumps and dropouts
  task automatic random_scan(input int len);
    int r, idx, step;
    r = $urandom_range(65535);
    idx = $urandom_range(4095);
    step = $urandom_range(3) == 0 ? $urandom_range(4095) : 1;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       r = $urandom_range(65535);
        1:       r = r + $urandom_range(800) - 400;
        default: r = r + $urandom_range(40) - 20;
      endcase
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      add_beam(r, $urandom_range(9) != 0, idx, i == len - 1);
      idx = (idx + step) % 4096;
    end
  endtask

  task automatic random_traffic(input int n);
    int len;
    while (n > 0) begin
      if ($urandom_range(19) == 0) begin
        add_beam($urandom, $urandom, $urandom, $urandom);
        n--;
      end else begin
        len = $urandom_range(1, 30);
        random_scan(len);
        n -= len;
      end
    end
  endtask

  task automatic drain();
    while (beam_q.size() > 0 || bi.valid || centroid_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] a, input logic [15:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      CFG_GAP_THRESHOLD: gap_thr   = d;
      CFG_MIN_POINTS:    min_pts   = 13'(d);
      CFG_ANGLE_START:   ang_start = d;
      CFG_ANGLE_STEP:    ang_step  = d;
      default: ;
    endcase
  endtask

  initial begin
    for (int k = 0; k < SINE_DEPTH; k++) sin_rom[k] = taylor_sine(16'(k << 6));
    gap_thr = 16'd300;
    min_pts = '0;
    ang_start = '0;
    ang_step = 16'd91;
    last_rng = '0;
    prev_valid = 1'b0;
    clear_cluster();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    bi.valid = 1'b0;
    bi.range_mm = '0;
    bi.range_valid = 1'b0;
    bi.beam_index = '0;
    bi.last_beam = 1'b0;
    co.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, jumps, dropouts, empty and single-point scans
    add_beam(0, 1, 0, 0);
    add_beam(65535, 1, 4095, 0);
    add_beam(65535, 0, 1, 0);
    add_beam(65400, 1, 2, 0);
    add_beam(100, 1, 3, 0);
    add_beam(120, 1, 4, 1);
    add_beam(500, 0, 0, 1);
    add_beam(65535, 1, 4095, 1);
    add_beam(1000, 1, 10, 0);
    add_beam(2000, 1, 11, 0);
    add_beam(2000, 0, 12, 1);
    add_beam(3000, 1, 100, 0);
    add_beam(3300, 1, 101, 0);
    add_beam(3601, 1, 102, 1);
    drain();

    // large minimum, zero gap, extreme angles
    cfg_write(CFG_GAP_THRESHOLD, 16'd0);
    cfg_write(CFG_MIN_POINTS, 16'd4096);
    cfg_write(CFG_ANGLE_START, 16'h8000);
    cfg_write(CFG_ANGLE_STEP, 16'hffff);
    random_traffic(250);
    drain();

    // swapped idling; receiver hold while beams keep coming
    send_idle = 48;
    recv_idle = 12;
    cfg_write(CFG_GAP_THRESHOLD, 16'hffff);
    cfg_write(CFG_MIN_POINTS, 16'd0);
    cfg_write(CFG_ANGLE_START, 16'h7fff);
    cfg_write(CFG_ANGLE_STEP, 16'd0);
    hold_token++;
    random_traffic(250);
    drain();

    send_idle = 0;
    recv_idle = 0;
    cfg_write(CFG_GAP_THRESHOLD, 16'($urandom_range(50, 1000)));
    cfg_write(CFG_MIN_POINTS, 16'd3);
    cfg_write(CFG_ANGLE_START, 16'($urandom));
    cfg_write(CFG_ANGLE_STEP, 16'($urandom));
    hold_token++;
    random_traffic(250);
    drain();

    send_idle = 12;
    recv_idle = 48;
    cfg_write(CFG_GAP_THRESHOLD, 16'd300);
    cfg_write(CFG_MIN_POINTS, 16'd1);
    cfg_write(CFG_ANGLE_STEP, 16'd91);
    random_traffic(250);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
